// ===== rtl/brb_pkg.sv =====
// Package of the circular byte FIFO: field widths, codes and the item types.
// Used by the FIFO core, its checker and the testbench; depends on nothing.
package brb_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int LEN_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef logic [CFG_W-1:0] t_cfg_word;

    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] data_byte;
        logic              burst_start;
        logic [LEN_W-1:0]  length;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] read_byte;
        logic              status;
        logic [LEN_W-1:0]  granted;
        logic              last;
    } t_out_item;

endpackage

// ===== rtl/brb_stream_if.sv =====
// Valid/ready channel interface carrying one payload of type T.
// Used for the request, result and configuration channels of the FIFO core.
interface brb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/brb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; the read data holds while no read is enabled.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/byte_ring_buffer_fifo_core.sv =====
// Top level of the circular byte FIFO: pointer control, read run sequencer,
// result register. Depends on brb_pkg, brb_stream_if and brb_ram.
//
// Requests arrive on i_in. A write byte with burst_start opens a burst of
// the given length; the burst is stored only if the free room covers it,
// and one status result follows its last byte. A read request returns
// min(length, fill) data results from the head, the last one marked, or a
// single empty result when nothing is granted. Results leave on o_out.
// The one register, the size of the ring in use, is written on i_cfg; a
// write also empties the FIFO.
// Write bytes are taken back to back while the result register is free. A
// read request of n bytes streams them at one per cycle from the storage
// RAM, whose registered read port sets that pace, while the receiver takes
// them; each byte passes the RAM read register and then the result register,
// and the next request is taken once the run has ended and the FIFO is idle.
// Reset empties the FIFO and sets the size to DEPTH; the storage is not
// cleared. When the receiver stalls, the result register and one RAM data
// stage hold their bytes and new requests wait.
module byte_ring_buffer_fifo_core #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    brb_stream_if.sink   i_in,
    brb_stream_if.source o_out,
    brb_stream_if.sink   i_cfg
);
    import brb_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_size, n_size;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_wr, n_wr;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic             r_rej, n_rej;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_grant, n_grant;
    logic             r_pend, n_pend;
    logic             r_pend_last, n_pend_last;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic              out_free;
    logic              in_acc;
    logic              move;
    logic              issue;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0] ram_rdata;
    t_in_item          req;
    logic [CNT_W:0]    wsum;
    logic [CNT_W-1:0]  room;
    logic [CNT_W-1:0]  rd_n;
    logic [CFG_W-1:0]  cfg_clamp;
    logic              cur_rej;
    logic [IDX_W-1:0]  cur_wr;
    logic [LEN_W-1:0]  cur_rem;
    logic              do_step;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] size);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(idx) + CNT_W'(1);
        return (nxt >= size) ? '0 : nxt[IDX_W-1:0];
    endfunction

    assign req      = i_in.data;
    assign out_free = !r_out_valid || o_out.ready;
    assign in_acc   = i_in.valid && i_in.ready;
    assign move     = (r_state == ST_READ) && r_pend && out_free;
    assign issue    = (r_state == ST_READ) && (r_left != '0) && (!r_pend || move);

    assign i_in.ready  = (r_state == ST_IDLE) && !r_pend && out_free;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign room = r_size - r_fill;
    assign wsum = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_fill);
    assign rd_n = (req.length < LEN_W'(r_fill)) ? CNT_W'(req.length) : r_fill;

    always_comb begin
        if (i_cfg.data == '0) begin
            cfg_clamp = CFG_W'(1);
        end else if (i_cfg.data > CFG_W'(DEPTH)) begin
            cfg_clamp = CFG_W'(DEPTH);
        end else begin
            cfg_clamp = i_cfg.data;
        end
    end

    always_comb begin
        logic [CNT_W:0] wtmp;
        n_state     = r_state;
        n_size      = r_size;
        n_head      = r_head;
        n_fill      = r_fill;
        n_wr        = r_wr;
        n_rem       = r_rem;
        n_rej       = r_rej;
        n_left      = r_left;
        n_grant     = r_grant;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_wr;
        cur_rej     = r_rej;
        cur_wr      = r_wr;
        cur_rem     = r_rem;
        do_step     = 1'b0;
        wtmp        = wsum;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (in_acc && req.operation == OP_READ) begin
            if (rd_n == '0) begin
                n_out_valid = 1'b1;
                n_out       = '{KIND_DATA, '0, STATUS_OK, '0, 1'b1};
            end else begin
                n_state = ST_READ;
                n_left  = rd_n;
                n_grant = rd_n;
                n_fill  = r_fill - rd_n;
            end
        end else if (in_acc) begin
            if (req.burst_start) begin
                if (req.length == '0) begin
                    n_rem       = '0;
                    n_rej       = 1'b0;
                    n_out_valid = 1'b1;
                    n_out       = '{KIND_STATUS, '0, STATUS_OK, '0, 1'b0};
                end else begin
                    cur_rem = req.length;
                    cur_rej = LEN_W'(room) < req.length;
                    if (!cur_rej) begin
                        if (wtmp >= (CNT_W + 1)'(r_size)) begin
                            wtmp = wtmp - (CNT_W + 1)'(r_size);
                        end
                        if (wtmp >= (CNT_W + 1)'(r_size)) begin
                            wtmp = '0;
                        end
                        cur_wr = wtmp[IDX_W-1:0];
                    end
                    do_step = 1'b1;
                end
            end else if (r_rem != '0) begin
                do_step = 1'b1;
            end
        end

        if (do_step) begin
            n_rej = cur_rej;
            n_wr  = cur_wr;
            if (!cur_rej && r_fill < r_size) begin
                ram_we    = 1'b1;
                ram_waddr = cur_wr;
                n_wr      = advance(cur_wr, r_size);
                n_fill    = r_fill + CNT_W'(1);
            end
            n_rem = cur_rem - LEN_W'(1);
            if (n_rem == '0) begin
                n_out_valid = 1'b1;
                n_out       = '{KIND_STATUS, '0, cur_rej ? STATUS_REJECT : STATUS_OK,
                                '0, 1'b0};
                n_rej       = 1'b0;
            end
        end

        if (move) begin
            n_out_valid = 1'b1;
            n_out       = '{KIND_DATA, ram_rdata, STATUS_OK, LEN_W'(r_grant), r_pend_last};
            n_pend      = 1'b0;
        end
        if (issue) begin
            n_head      = advance(r_head, r_size);
            n_left      = r_left - CNT_W'(1);
            n_pend      = 1'b1;
            n_pend_last = (r_left == CNT_W'(1));
        end
        if (r_state == ST_READ && r_left == '0 && !r_pend) begin
            n_state = ST_IDLE;
        end

        if (i_cfg.valid) begin
            n_size = CNT_W'(cfg_clamp);
            n_head = '0;
            n_fill = '0;
            n_wr   = '0;
            n_rem  = '0;
            n_rej  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= CNT_W'(DEPTH);
            r_head      <= '0;
            r_fill      <= '0;
            r_wr        <= '0;
            r_rem       <= '0;
            r_rej       <= 1'b0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_wr        <= n_wr;
            r_rem       <= n_rem;
            r_rej       <= n_rej;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grant     <= n_grant;
        r_pend_last <= n_pend_last;
        r_out       <= n_out;
    end

    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (req.data_byte),
        .i_re    (issue),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );
endmodule

// ===== rtl/brb_checker.sv =====
// Port-level checker for the circular byte FIFO core and its bind statement.
// Depends on brb_pkg; attaches to byte_ring_buffer_fifo_core.
module brb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input brb_pkg::t_out_item i_out_data
);
    import brb_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid right after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("Stalled result changed or dropped.");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.kind == KIND_STATUS) |->
        (i_out_data.granted == '0 && !i_out_data.last && i_out_data.read_byte == '0))
        else $error("Status result carries read fields.");

    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.kind == KIND_DATA && i_out_data.granted == '0) |->
        (i_out_data.last && i_out_data.read_byte == '0))
        else $error("Empty read result is malformed.");

    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_data.kind == KIND_DATA && !i_out_data.last)
        |-> !i_in_ready)
        else $error("Request taken in the middle of a read run.");
endmodule

bind byte_ring_buffer_fifo_core brb_checker u_brb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== tb/sv/byte_ring_buffer_fifo_core_test.sv =====
// Self-checking testbench of the circular byte FIFO core, with a scoreboard class
// that predicts every result and checks results in order.
// Depends on brb_pkg, brb_stream_if and byte_ring_buffer_fifo_core.
module byte_ring_buffer_fifo_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import brb_pkg::*;

    localparam int RING_DEPTH   = DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_TICKS = 16;
    localparam int REPORT_MAX   = 10;

    class ring_fifo_tracker;
        logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
        int unsigned slots;
        int unsigned head_ptr;
        int unsigned fill_cnt;
        int unsigned tail_ptr;
        int unsigned burst_left;
        bit          burst_drop;
        t_out_item   pending_results [$];
        int unsigned mismatches;

        function new();
            slots      = RING_DEPTH;
            mismatches = 0;
            clear_ring();
        endfunction

        function void clear_ring();
            head_ptr   = 0;
            fill_cnt   = 0;
            tail_ptr   = 0;
            burst_left = 0;
            burst_drop = 1'b0;
        endfunction

        function void set_size(t_cfg_word value);
            slots = value;
            if (slots == 0) begin
                slots = 1;
            end
            if (slots > RING_DEPTH) begin
                slots = RING_DEPTH;
            end
            clear_ring();
        endfunction

        function t_out_item make_result(logic kind, logic [BYTE_W-1:0] rd_byte,
                                        logic status, int unsigned granted, logic last);
            t_out_item res;
            res.kind      = kind;
            res.read_byte = rd_byte;
            res.status    = status;
            res.granted   = granted[LEN_W-1:0];
            res.last      = last;
            return res;
        endfunction

        function void take_request(t_in_item req);
            int unsigned grant;
            int unsigned room;
            int unsigned pos;
            if (req.operation == OP_READ) begin
                grant = (req.length < fill_cnt) ? req.length : fill_cnt;
                if (grant == 0) begin
                    pending_results.push_back(make_result(KIND_DATA, '0, STATUS_OK, 0, 1'b1));
                    return;
                end
                for (int unsigned i = 0; i < grant; i++) begin
                    pending_results.push_back(make_result(KIND_DATA, ring_mem[head_ptr],
                                                          STATUS_OK, grant, i + 1 == grant));
                    head_ptr = (head_ptr + 1 >= slots) ? 0 : head_ptr + 1;
                end
                fill_cnt -= grant;
                return;
            end
            if (req.burst_start) begin
                room = (slots > fill_cnt) ? slots - fill_cnt : 0;
                if (req.length == 0) begin
                    burst_left = 0;
                    burst_drop = 1'b0;
                    pending_results.push_back(make_result(KIND_STATUS, '0, STATUS_OK, 0, 1'b0));
                    return;
                end
                burst_left = req.length;
                burst_drop = room < req.length;
                if (!burst_drop) begin
                    pos = head_ptr + fill_cnt;
                    if (pos >= slots) begin
                        pos -= slots;
                    end
                    if (pos >= slots) begin
                        pos = 0;
                    end
                    tail_ptr = pos;
                end
            end else if (burst_left == 0) begin
                return;
            end
            if (!burst_drop && fill_cnt < slots) begin
                ring_mem[tail_ptr] = req.data_byte;
                tail_ptr = (tail_ptr + 1 >= slots) ? 0 : tail_ptr + 1;
                fill_cnt++;
            end
            burst_left--;
            if (burst_left == 0) begin
                pending_results.push_back(make_result(KIND_STATUS, '0,
                    burst_drop ? STATUS_REJECT : STATUS_OK, 0, 1'b0));
                burst_drop = 1'b0;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                if (mismatches < REPORT_MAX) begin
                    $display("unexpected result: kind %0d byte %02h status %0d granted %0d last %0d",
                             got.kind, got.read_byte, got.status, got.granted, got.last);
                end
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.read_byte !== want.read_byte ||
                got.status !== want.status || got.granted !== want.granted ||
                got.last !== want.last) begin
                if (mismatches < REPORT_MAX) begin
                    $display("result mismatch: expected kind %0d byte %02h status %0d granted %0d last %0d",
                             want.kind, want.read_byte, want.status, want.granted, want.last);
                    $display("                 actual   kind %0d byte %02h status %0d granted %0d last %0d",
                             got.kind, got.read_byte, got.status, got.granted, got.last);
                end
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    int unsigned cycle_cnt = 0;
    bit          calm_phase = 1'b0;
    ring_fifo_tracker ring_track;

    brb_stream_if #(.T(t_in_item))  req_if ();
    brb_stream_if #(.T(t_out_item)) res_if ();
    brb_stream_if #(.T(t_cfg_word)) cfg_if ();

    byte_ring_buffer_fifo_core #(.DEPTH(RING_DEPTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("byte_ring_buffer_fifo_core regression: fail");
            $finish;
        end
    end

    function automatic t_in_item make_req(logic op, logic [BYTE_W-1:0] data_byte,
                                          logic start, int unsigned len);
        t_in_item req;
        req.operation   = op;
        req.data_byte   = data_byte;
        req.burst_start = start;
        req.length      = len[LEN_W-1:0];
        return req;
    endfunction

    task automatic send_request(input t_in_item req);
        int unsigned gap;
        gap = calm_phase ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.data  = req;
        req_if.valid = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        ring_track.take_request(req);
        @(negedge i_clk);
    endtask

    task automatic send_read(input int unsigned len);
        send_request(make_req(OP_READ, BYTE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), len));
    endtask

    task automatic send_burst(input int unsigned len, input int unsigned count);
        send_request(make_req(OP_WRITE, BYTE_W'($urandom_range(0, 255)), 1'b1, len));
        for (int unsigned i = 1; i < count; i++) begin
            send_request(make_req(OP_WRITE, BYTE_W'($urandom_range(0, 255)), 1'b0,
                                  $urandom_range(0, 64)));
        end
    endtask

    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (ring_track.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic write_size(input t_cfg_word value);
        wait_drained();
        cfg_if.data  = value;
        cfg_if.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        ring_track.set_size(value);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned used;
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        used = 0;
        while (used < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 6);
                send_burst(len, (len == 0) ? 1 : len);
                used += (len == 0) ? 1 : len;
            end else if (pick < 80) begin
                len = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(0, 8);
                send_read(len);
                used++;
            end else if (pick < 88) begin
                len = $urandom_range(2, 64);
                cut = $urandom_range(1, (len - 1 < 4) ? len - 1 : 4);
                send_burst(len, cut);
                used += cut;
            end else if (pick < 94) begin
                send_request(make_req(OP_WRITE, BYTE_W'($urandom_range(0, 255)), 1'b0,
                                      $urandom_range(0, 64)));
            end else begin
                send_burst(3, 1);
                send_read($urandom_range(1, 3));
                send_burst(0, 0);
                send_read(64);
                used += 4;
            end
        end
    endtask

    initial begin
        int unsigned gap;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = calm_phase ? 0 : $urandom_range(0, 9);
            if (gap != 0) begin
                res_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_if.ready = 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            ring_track.check_result(res_if.data);
            @(negedge i_clk);
        end
    end

    initial begin
        t_cfg_word phase_size [6];
        ring_track   = new();
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        phase_size[0] = t_cfg_word'(0);
        phase_size[1] = t_cfg_word'(127);
        phase_size[2] = t_cfg_word'(1);
        phase_size[3] = t_cfg_word'(64);
        phase_size[4] = t_cfg_word'($urandom_range(2, 63));
        phase_size[5] = t_cfg_word'(3);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_read(5);
        send_read(0);
        send_request(make_req(OP_WRITE, 8'hFF, 1'b0, 64));
        send_burst(0, 1);
        send_request(make_req(OP_WRITE, 8'h00, 1'b1, 3));
        send_request(make_req(OP_WRITE, 8'hFF, 1'b0, 0));
        send_request(make_req(OP_WRITE, 8'hA5, 1'b0, 0));
        send_read(64);

        write_size(t_cfg_word'(4));
        send_burst(4, 4);
        send_burst(1, 1);
        send_read(2);
        send_burst(2, 2);
        send_read(64);
        send_burst(3, 2);
        send_burst(1, 1);
        send_burst(2, 1);
        send_read(1);
        send_request(make_req(OP_WRITE, 8'h5A, 1'b0, 0));
        send_read(64);
        send_burst(5, 5);

        for (int p = 0; p < 6; p++) begin
            write_size(phase_size[p]);
            calm_phase = (p == 2);
            random_phase(4);
            if (p == 3) begin
                req_if.valid = 1'b0;
                while (ring_track.outstanding() != 0) begin
                    @(posedge i_clk);
                end
                @(negedge i_clk);
            end
            random_phase(4);
        end
        calm_phase = 1'b0;

        req_if.valid = 1'b0;
        while (ring_track.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (ring_track.mismatches == 0 && ring_track.outstanding() == 0) begin
            $display("byte_ring_buffer_fifo_core regression: pass");
        end else begin
            $display("byte_ring_buffer_fifo_core regression: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/brb_pkg.sv
rtl/brb_stream_if.sv
rtl/brb_ram.sv
rtl/byte_ring_buffer_fifo_core.sv
rtl/brb_checker.sv
tb/sv/byte_ring_buffer_fifo_core_test.sv
